### design/hsten_pkg.sv
// shared constants and types for the five-point heat stencil block
// no dependencies; compiled first
`default_nettype none

package hsten_pkg;

   // sample and register widths
   localparam int DATA_W           = 32;
   localparam int RATE_W           = 16;
   localparam int GRID_SIZE_W      = 6;
   localparam int FRAC_W           = 16;

   // arithmetic widths of the stencil datapath
   localparam int PART_W           = DATA_W + 1;
   localparam int LAP_W            = DATA_W + 3;
   localparam int PROD_W           = LAP_W + RATE_W + 1;
   localparam int SUM_W            = PROD_W - FRAC_W + 1;

   // grid limits and reset values
   localparam int MIN_GRID         = 3;
   localparam int GRID_MAX_DEFAULT = 32;
   localparam int GRID_SIZE_RESET  = 32;

   // front to back queue
   localparam int QUEUE_DEPTH      = 4;

   // register port
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;

   typedef enum logic {
      REG_RATE_COEFF = 1'b0,
      REG_GRID_SIZE  = 1'b1
   } csr_index_type;

   // classification of one item, handed from front to back
   typedef struct packed {
      logic sel;        // buffer holding the newest completed row
      logic emit;       // item produces a result
      logic stencil;    // interior cell, full update
      logic done;       // last cell of an updated grid
      logic col_first;  // column zero
   } item_ctl_type;

endpackage

`default_nettype wire

### design/hsten_if.sv
// request and response channel interfaces of the heat stencil block
// depends on hsten_pkg
`default_nettype none

interface hsten_req_if
   import hsten_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] temp_in;

   modport source (output valid, output temp_in, input ready);
   modport sink   (input valid, input temp_in, output ready);
endinterface

interface hsten_rsp_if
   import hsten_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] temp_out;
   logic                     grid_done;

   modport source (output valid, output temp_out, output grid_done, input ready);
   modport sink   (input valid, input temp_out, input grid_done, output ready);
endinterface

`default_nettype wire

### design/hsten_front.sv
// front end: raster position tracking and per-item classification
// depends on hsten_pkg and hsten_req_if
`default_nettype none

module hsten_front
   import hsten_pkg::*;
#(
   parameter int GRID_MAX = GRID_MAX_DEFAULT,
   localparam int COL_W = $clog2(GRID_MAX)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   hsten_req_if.sink                     req,
   input  wire logic [GRID_SIZE_W-1:0]   grid_size,
   output logic                          push_valid,
   input  wire logic                     push_ready,
   output logic signed [DATA_W-1:0]      push_temp,
   output logic [COL_W-1:0]              push_col,
   output item_ctl_type                  push_ctl
);

   localparam int SIZE_W = $clog2(GRID_MAX + 1);
   localparam int CMP_W  = (SIZE_W > GRID_SIZE_W) ? SIZE_W : GRID_SIZE_W;

   logic [COL_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic              sel_ff, sel_in;
   logic              tail_pend_ff, tail_pend_in;
   logic [SIZE_W-1:0] tail_len_ff, tail_len_in;

   logic              accept;
   logic              grid_start;
   logic [CMP_W-1:0]  size_req;
   logic [SIZE_W-1:0] size_clamped;
   logic [SIZE_W-1:0] side;
   logic [SIZE_W-1:0] row_ext;
   logic [SIZE_W-1:0] col_ext;
   logic              first_row;
   logic              first_col;
   logic              last_col;

   // handshake straight through to the queue
   assign accept     = req.valid && push_ready;
   assign req.ready  = push_ready;
   assign push_valid = req.valid;
   assign push_temp  = req.temp_in;
   assign push_col   = col_ff;

   // side length: clamped to MIN_GRID..GRID_MAX, sampled at the first sample of every grid
   always_comb begin
      size_req = CMP_W'(grid_size);
      if (size_req < CMP_W'(MIN_GRID)) begin
         size_clamped = SIZE_W'(MIN_GRID);
      end else if (size_req > CMP_W'(GRID_MAX)) begin
         size_clamped = SIZE_W'(GRID_MAX);
      end else begin
         size_clamped = SIZE_W'(size_req);
      end
   end

   assign grid_start = (row_ff == '0) && (col_ff == '0);
   assign side       = grid_start ? size_clamped : size_ff;
   assign row_ext    = SIZE_W'(row_ff);
   assign col_ext    = SIZE_W'(col_ff);
   assign first_row  = (row_ff == '0);
   assign first_col  = (col_ff == '0);
   assign last_col   = (col_ext == side - SIZE_W'(1));

   // classify the item: tail of previous grid, boundary or interior
   always_comb begin
      push_ctl.sel       = sel_ff;
      push_ctl.col_first = first_col;
      push_ctl.emit      = first_row ? (tail_pend_ff && (col_ext < tail_len_ff)) : 1'b1;
      push_ctl.done      = first_row && (col_ext == tail_len_ff - SIZE_W'(1));
      push_ctl.stencil   = !first_row && (row_ff != COL_W'(1)) && !first_col && !last_col;
   end

   // raster counters and tail bookkeeping
   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      size_in      = size_ff;
      sel_in       = sel_ff;
      tail_pend_in = tail_pend_ff;
      tail_len_in  = tail_len_ff;
      if (accept) begin
         size_in = side;
         if (first_row && last_col) begin
            tail_pend_in = 1'b0;
         end
         if (last_col) begin
            col_in = '0;
            sel_in = !sel_ff;
            if (row_ext + SIZE_W'(1) == side) begin
               row_in       = '0;
               tail_pend_in = 1'b1;
               tail_len_in  = side;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         size_ff      <= SIZE_W'(GRID_MAX);
         sel_ff       <= 1'b0;
         tail_pend_ff <= 1'b0;
         tail_len_ff  <= '0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         size_ff      <= size_in;
         sel_ff       <= sel_in;
         tail_pend_ff <= tail_pend_in;
         tail_len_ff  <= tail_len_in;
      end
   end

`ifndef ASSERT_OFF
   // inside a grid the position stays within the latched side
   a_pos_in_grid: assert property (@(posedge clock) disable iff (reset)
      !grid_start |-> (row_ext < size_ff) && (col_ext < size_ff))
      else $error("raster position outside grid");

   // a pending tail row always has a legal length
   a_tail_len: assert property (@(posedge clock) disable iff (reset)
      tail_pend_ff |-> (tail_len_ff >= SIZE_W'(MIN_GRID)))
      else $error("pending tail row with illegal length");
`endif

endmodule

`default_nettype wire

### design/hsten_queue.sv
// short register queue that decouples classification from execution
// depends on hsten_pkg
`default_nettype none

module hsten_queue
   import hsten_pkg::*;
#(
   parameter int COL_W = $clog2(GRID_MAX_DEFAULT)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push_valid,
   output logic                          push_ready,
   input  wire logic signed [DATA_W-1:0] push_temp,
   input  wire logic [COL_W-1:0]         push_col,
   input  wire item_ctl_type             push_ctl,
   output logic                          pop_valid,
   input  wire logic                     pop,
   output logic signed [DATA_W-1:0]      pop_temp,
   output logic [COL_W-1:0]              pop_col,
   output item_ctl_type                  pop_ctl
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic signed [DATA_W-1:0] temp_q_ff [QUEUE_DEPTH];
   logic [COL_W-1:0]         col_q_ff  [QUEUE_DEPTH];
   item_ctl_type             ctl_q_ff  [QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   assign pop_temp = temp_q_ff[rd_ptr_ff];
   assign pop_col  = col_q_ff[rd_ptr_ff];
   assign pop_ctl  = ctl_q_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         temp_q_ff[wr_ptr_ff] <= push_temp;
         col_q_ff[wr_ptr_ff]  <= push_col;
         ctl_q_ff[wr_ptr_ff]  <= push_ctl;
      end
   end

`ifndef ASSERT_OFF
   // a push without a pop raises the fill level by one
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("queue fill level out of step");
`endif

endmodule

`default_nettype wire

### design/hsten_back.sv
// back end: line buffers, stencil window and the update pipeline
// depends on hsten_pkg and hsten_rsp_if
`default_nettype none

module hsten_back
   import hsten_pkg::*;
#(
   parameter int GRID_MAX = GRID_MAX_DEFAULT,
   localparam int COL_W = $clog2(GRID_MAX)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_valid,
   output logic                          q_pop,
   input  wire logic signed [DATA_W-1:0] q_temp,
   input  wire logic [COL_W-1:0]         q_col,
   input  wire item_ctl_type             q_ctl,
   input  wire logic [RATE_W-1:0]        rate_coeff,
   hsten_rsp_if.source                   rsp
);

   // line buffers
   logic [DATA_W-1:0] buf_a_ff [GRID_MAX];
   logic [DATA_W-1:0] buf_b_ff [GRID_MAX];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;
   logic [COL_W-1:0]  east_addr;
   logic [COL_W-1:0]  addr_a;
   logic [COL_W-1:0]  addr_b;
   logic signed [DATA_W-1:0] col0_ff;

   // stage valids and stall enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_v_ff;
   logic load1, load2, load3, load4, load_out;

   // stage 1: read data and window
   logic signed [DATA_W-1:0] s1_south_ff;
   logic signed [DATA_W-1:0] s1_col0_ff;
   item_ctl_type             s1_ctl_ff;
   logic signed [DATA_W-1:0] east_hold_ff;
   logic signed [DATA_W-1:0] center_hold_ff;
   logic signed [DATA_W-1:0] s1_east, s1_north, s1_center, s1_west;
   logic signed [PART_W-1:0] s1_ns, s1_ew;

   // stage 2: partial sums
   item_ctl_type             s2_ctl_ff;
   logic signed [DATA_W-1:0] s2_center_ff;
   logic signed [PART_W-1:0] s2_ns_ff, s2_ew_ff;
   logic signed [LAP_W-1:0]  s2_lap;

   // stage 3: laplacian
   item_ctl_type             s3_ctl_ff;
   logic signed [DATA_W-1:0] s3_center_ff;
   logic signed [LAP_W-1:0]  s3_lap_ff;
   logic signed [RATE_W:0]   rate_s;
   logic signed [PROD_W-1:0] s3_prod;

   // stage 4: scaled product
   item_ctl_type             s4_ctl_ff;
   logic signed [DATA_W-1:0] s4_center_ff;
   logic signed [PROD_W-1:0] s4_prod_ff;
   logic signed [SUM_W-1:0]  s4_sum;
   logic                     s4_ovf;
   logic signed [DATA_W-1:0] out_temp_in;

   // output register
   logic signed [DATA_W-1:0] out_temp_ff;
   logic                     out_done_ff;

   function automatic logic signed [DATA_W-1:0] q_ctl_sel_east(
      input logic sel, input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
      return sel ? $signed(b) : $signed(a);
   endfunction

   // stall chain from the receiver back to the queue
   assign load_out = !rsp_v_ff || rsp.ready;
   assign load4    = !v4_ff || load_out;
   assign load3    = !v3_ff || load4;
   assign load2    = !v2_ff || load3;
   assign load1    = !v1_ff || load2;
   assign q_pop    = q_valid && load1;

   // newest row read one column ahead, older row read at the column
   assign east_addr = (q_col == COL_W'(GRID_MAX - 1)) ? '0 : q_col + 1'b1;
   assign addr_a    = q_ctl.sel ? q_col : east_addr;
   assign addr_b    = q_ctl.sel ? east_addr : q_col;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_a_ff <= buf_a_ff[addr_a];
         rd_b_ff <= buf_b_ff[addr_b];
         if (q_ctl.sel) begin
            buf_a_ff[q_col] <= q_temp;
         end else begin
            buf_b_ff[q_col] <= q_temp;
         end
      end
   end

   // column zero of the row being written, used as center one row later
   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_south_ff <= q_temp;
         s1_ctl_ff   <= q_ctl;
         s1_col0_ff  <= col0_ff;
         if (q_ctl.col_first) begin
            col0_ff <= q_temp;
         end
      end
   end

   // stencil window along the newest row
   assign s1_east   = q_ctl_sel_east(s1_ctl_ff.sel, rd_a_ff, rd_b_ff);
   assign s1_north  = s1_ctl_ff.sel ? $signed(rd_a_ff) : $signed(rd_b_ff);
   assign s1_center = s1_ctl_ff.col_first ? s1_col0_ff : east_hold_ff;
   assign s1_west   = center_hold_ff;
   assign s1_ns     = PART_W'(s1_north) + PART_W'(s1_south_ff);
   assign s1_ew     = PART_W'(s1_east) + PART_W'(s1_west);

   always_ff @(posedge clock) begin
      if (v1_ff && load2) begin
         east_hold_ff   <= s1_east;
         center_hold_ff <= s1_center;
      end
      if (load2) begin
         s2_ctl_ff    <= s1_ctl_ff;
         s2_center_ff <= s1_center;
         s2_ns_ff     <= s1_ns;
         s2_ew_ff     <= s1_ew;
      end
   end

   // laplacian: n + s + e + w - 4c
   assign s2_lap = LAP_W'(s2_ns_ff) + LAP_W'(s2_ew_ff) - (LAP_W'(s2_center_ff) <<< 2);

   always_ff @(posedge clock) begin
      if (load3) begin
         s3_ctl_ff    <= s2_ctl_ff;
         s3_center_ff <= s2_center_ff;
         s3_lap_ff    <= s2_lap;
      end
   end

   // scale by the diffusion ratio
   assign rate_s  = $signed({1'b0, rate_coeff});
   assign s3_prod = PROD_W'(s3_lap_ff) * PROD_W'(rate_s);

   always_ff @(posedge clock) begin
      if (load4) begin
         s4_ctl_ff    <= s3_ctl_ff;
         s4_center_ff <= s3_center_ff;
         s4_prod_ff   <= s3_prod;
      end
   end

   // floor shift, add to center, clamp to the sample range; other cells pass the center
   assign s4_sum = SUM_W'(s4_center_ff) + SUM_W'($signed(s4_prod_ff[PROD_W-1:FRAC_W]));
   assign s4_ovf = !((&s4_sum[SUM_W-1:DATA_W-1]) || !(|s4_sum[SUM_W-1:DATA_W-1]));

   always_comb begin
      if (!s4_ctl_ff.stencil) begin
         out_temp_in = s4_center_ff;
      end else if (s4_ovf) begin
         out_temp_in = s4_sum[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                       : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         out_temp_in = s4_sum[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_temp_ff <= out_temp_in;
         out_done_ff <= s4_ctl_ff.done;
      end
   end

   // stage valids; items with no result vanish at the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (load1) begin
            v1_ff <= q_valid;
         end
         if (load2) begin
            v2_ff <= v1_ff;
         end
         if (load3) begin
            v3_ff <= v2_ff;
         end
         if (load4) begin
            v4_ff <= v3_ff;
         end
         if (load_out) begin
            rsp_v_ff <= v4_ff && s4_ctl_ff.emit;
         end
      end
   end

   assign rsp.valid     = rsp_v_ff;
   assign rsp.temp_out  = out_temp_ff;
   assign rsp.grid_done = out_done_ff;

`ifndef ASSERT_OFF
   // interior cells never sit in column zero, where the window restarts
   a_stencil_col: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && s1_ctl_ff.stencil) |-> !s1_ctl_ff.col_first)
      else $error("interior update at column zero");

   // a new result only comes from an emitting item in the last stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_v_ff) |-> $past(v4_ff && s4_ctl_ff.emit))
      else $error("result without an emitting item");
`endif

endmodule

`default_nettype wire

### design/heat_stencil_2d_step.sv
// Five-point heat stencil, one forward-Euler step per pass over a square grid.
// Samples (signed Q16.16) enter on req_chan in raster order, one item per
// valid/ready handshake; updated samples leave on rsp_chan in raster order.
// Each result is the cell one row behind the input, so the last row of a grid
// comes out while the first row of the next grid goes in; grid_done marks its
// last cell. The first row after reset produces no results.
// Registers on the csr_ port: rate_coeff at 0x0 (Q0.16), grid_size at 0x4,
// latched at the first sample of each grid and clamped to 3..GRID_MAX.
// Throughput is one item per cycle while rsp_chan does not stall; both line
// buffers are read and one of them is written per item. A taken item passes
// the queue, then buffer read, partial sums, laplacian and multiply stages,
// then the output register.
// Reset clears counters, queue and pipeline; the line buffers are not cleared
// and need no clearing pass. When rsp_chan stalls the pipeline holds, the
// four-entry queue fills and then req_chan.ready drops.
// depends on hsten_pkg, hsten_if, hsten_front, hsten_queue and hsten_back
`default_nettype none

module heat_stencil_2d_step
   import hsten_pkg::*;
#(
   parameter int GRID_MAX = GRID_MAX_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   hsten_req_if.sink                  req_chan,
   hsten_rsp_if.source                rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   localparam int COL_W = $clog2(GRID_MAX);

   logic [RATE_W-1:0]      rate_coeff_ff;
   logic [GRID_SIZE_W-1:0] grid_size_ff;
   logic                   csr_write;
   csr_index_type          csr_index;

   logic                     push_valid, push_ready;
   logic signed [DATA_W-1:0] push_temp;
   logic [COL_W-1:0]         push_col;
   item_ctl_type             push_ctl;

   logic                     pop_valid, pop;
   logic signed [DATA_W-1:0] pop_temp;
   logic [COL_W-1:0]         pop_col;
   item_ctl_type             pop_ctl;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_coeff_ff <= '0;
         grid_size_ff  <= GRID_SIZE_W'(GRID_SIZE_RESET);
      end else if (csr_write) begin
         case (csr_index)
            REG_RATE_COEFF: begin
               rate_coeff_ff <= csr_pwdata[RATE_W-1:0];
            end
            REG_GRID_SIZE: begin
               grid_size_ff <= csr_pwdata[GRID_SIZE_W-1:0];
            end
            default: begin
               rate_coeff_ff <= rate_coeff_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_RATE_COEFF: csr_prdata = CSR_DATA_W'(rate_coeff_ff);
         REG_GRID_SIZE:  csr_prdata = CSR_DATA_W'(grid_size_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // classification
   hsten_front #(.GRID_MAX(GRID_MAX)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .grid_size  (grid_size_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_temp  (push_temp),
      .push_col   (push_col),
      .push_ctl   (push_ctl)
   );

   // decoupling queue
   hsten_queue #(.COL_W(COL_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_temp  (push_temp),
      .push_col   (push_col),
      .push_ctl   (push_ctl),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_temp   (pop_temp),
      .pop_col    (pop_col),
      .pop_ctl    (pop_ctl)
   );

   // execution
   hsten_back #(.GRID_MAX(GRID_MAX)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (pop_valid),
      .q_pop      (pop),
      .q_temp     (pop_temp),
      .q_col      (pop_col),
      .q_ctl      (pop_ctl),
      .rate_coeff (rate_coeff_ff),
      .rsp        (rsp_chan)
   );

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking bench for the five-point heat stencil: drives whole and broken grids
// through heat_stencil_2d_step and checks every result in order against an in-bench predictor.
// Depends on hsten_pkg, hsten_if and the heat_stencil_2d_step RTL.
`default_nettype none

module testbench;
   import hsten_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD    = 10;
   localparam int IDLE_PCT      = 22;
   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_ITEMS  = 1240;
   localparam int CYCLE_LIMIT   = 200000;

   localparam logic signed [DATA_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
   localparam longint SUM_MAX = 64'sd2147483647;
   localparam longint SUM_MIN = -64'sd2147483648;

   typedef enum int {
      STYLE_SMALL,
      STYLE_FULL,
      STYLE_EXTREME
   } sample_style_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] temp;
      logic                     done;
   } updated_cell_type;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   hsten_req_if req_chan ();
   hsten_rsp_if rsp_chan ();

   heat_stencil_2d_step #(
      .GRID_MAX(GRID_MAX_DEFAULT)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // clock
   always #(CLK_PERIOD / 2) clock = ~clock;

   // predictor state: two line stores, raster position, pending last row
   logic signed [DATA_W-1:0] line_mem [2][GRID_MAX_DEFAULT];
   bit                       last_bank     = 1'b0;
   int unsigned              cur_row       = 0;
   int unsigned              cur_col       = 0;
   int unsigned              grid_side     = GRID_SIZE_RESET;
   bit                       flush_pending = 1'b0;
   int unsigned              flush_len     = 0;
   logic [RATE_W-1:0]        rate_q16      = '0;
   logic [GRID_SIZE_W-1:0]   side_reg      = GRID_SIZE_RESET;

   updated_cell_type updated_cells [$];
   int               failures       = 0;
   bit               send_gaps_on   = 1'b1;
   bit               sink_stalls_on = 1'b1;
   int               hold_request   = 0;

   function automatic int unsigned clamp_side(input logic [GRID_SIZE_W-1:0] side);
      if (side < MIN_GRID) return MIN_GRID;
      if (side > GRID_MAX_DEFAULT) return GRID_MAX_DEFAULT;
      return side;
   endfunction

   // center plus scaled laplacian, floor shift, saturated to 32 bits
   function automatic logic signed [DATA_W-1:0] heat_update(
      input logic signed [DATA_W-1:0] center, north, south, west, east);
      longint lap;
      longint delta;
      longint total;
      lap = longint'(north) + longint'(south) + longint'(west) + longint'(east)
            - 4 * longint'(center);
      delta = (lap * longint'(rate_q16)) >>> FRAC_W;
      total = longint'(center) + delta;
      if (total > SUM_MAX) total = SUM_MAX;
      if (total < SUM_MIN) total = SUM_MIN;
      return total[DATA_W-1:0];
   endfunction

   // advance the grid by one sample and queue the result it releases, if any
   function automatic void apply_heat_step(input logic signed [DATA_W-1:0] sample);
      int unsigned      n;
      int unsigned      c;
      bit               older;
      updated_cell_type upd;
      if (cur_row == 0 && cur_col == 0) grid_side = clamp_side(side_reg);
      n = grid_side;
      if (cur_row >= n) cur_row = 0;
      if (cur_col >= n) cur_col = 0;
      c = cur_col;
      older = ~last_bank;

      if (cur_row == 0) begin
         // last row of the previous grid drains during the first row
         if (flush_pending && c < flush_len) begin
            upd.temp = line_mem[last_bank][c];
            upd.done = (c == flush_len - 1);
            updated_cells.push_back(upd);
         end
         if (c == n - 1) flush_pending = 1'b0;
      end else begin
         upd.done = 1'b0;
         if (cur_row == 1 || c == 0 || c == n - 1) begin
            upd.temp = line_mem[last_bank][c];
         end else begin
            upd.temp = heat_update(line_mem[last_bank][c], line_mem[older][c], sample,
                                   line_mem[last_bank][c - 1], line_mem[last_bank][c + 1]);
         end
         updated_cells.push_back(upd);
      end

      line_mem[older][c] = sample;

      // raster position
      cur_col = c + 1;
      if (cur_col >= n) begin
         cur_col = 0;
         last_bank = ~last_bank;
         cur_row++;
         if (cur_row >= n) begin
            cur_row = 0;
            flush_pending = 1'b1;
            flush_len = n;
         end
      end
   endfunction

   function automatic int unsigned samples_left_in_grid();
      if (cur_row == 0 && cur_col == 0) return 0;
      return grid_side * grid_side - cur_row * grid_side - cur_col;
   endfunction

   // one register access: setup cycle, then access cycle until pready
   task automatic csr_access(input bit write, input csr_index_type idx,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CSR_ADDR_W'(int'(idx) * 4);
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // write a register, mirror it in the predictor, read it back
   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      logic [CSR_DATA_W-1:0] written;
      csr_access(1'b1, idx, value, readback);
      if (idx == REG_RATE_COEFF) begin
         rate_q16 = value[RATE_W-1:0];
         written  = CSR_DATA_W'(rate_q16);
      end else begin
         side_reg = value[GRID_SIZE_W-1:0];
         written  = CSR_DATA_W'(side_reg);
      end
      csr_access(1'b0, idx, '0, readback);
      if (readback !== written) begin
         $display("%0t: register %s readback, expected %h, got %h",
                  $time, idx.name(), written, readback);
         failures++;
      end
   endtask

   // offer one item, optionally after random idle cycles, and wait for it to be taken
   task automatic send_sample(input logic signed [DATA_W-1:0] sample);
      int gap;
      gap = 0;
      if (send_gaps_on) while ($urandom_range(99) < IDLE_PCT) gap++;
      if (gap > 0) begin
         @(negedge clock) req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid   <= 1'b1;
      req_chan.temp_in <= sample;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      apply_heat_step(sample);
   endtask

   task automatic end_stream();
      @(negedge clock) req_chan.valid <= 1'b0;
   endtask

   task automatic send_samples(input int unsigned count, input sample_style_type style);
      logic signed [DATA_W-1:0] sample;
      for (int unsigned i = 0; i < count; i++) begin
         case (style)
            STYLE_SMALL: sample = $urandom_range(0, 1 << 21) - (1 << 20);
            STYLE_FULL:  sample = $urandom;
            default: begin
               case ($urandom_range(4))
                  0:       sample = SAMPLE_MAX;
                  1:       sample = SAMPLE_MIN;
                  2:       sample = '0;
                  3:       sample = -1;
                  default: sample = $urandom | 32'h7FFF_0000;
               endcase
            end
         endcase
         send_sample(sample);
      end
      end_stream();
   endtask

   // wait for every queued result, then let items with no result clear the pipeline
   task automatic drain_results();
      while (updated_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // saturation both ways, floor rounding, boundaries, first grid, clamped and dropped row
   task automatic test_directed_grids();
      logic signed [DATA_W-1:0] spike_grid [16] = '{
         SAMPLE_MAX, 0,          0,          -1,
         0,          SAMPLE_MIN, 0,          0,
         0,          0,          SAMPLE_MAX, 0,
         1,          0,          0,          SAMPLE_MIN
      };
      logic signed [DATA_W-1:0] edge_grid [9] = '{
         32'sh0001_0000, SAMPLE_MIN,     SAMPLE_MAX,
         -1,             32'sh4000_0000, 1,
         SAMPLE_MAX,     SAMPLE_MIN,     0
      };
      drain_results();
      csr_write(REG_RATE_COEFF, 32'h0000_FFFF);
      csr_write(REG_GRID_SIZE, 32'd4);
      foreach (spike_grid[i]) send_sample(spike_grid[i]);
      end_stream();
      // size below range clamps to 3; the pending 4-wide row is cut short
      drain_results();
      csr_write(REG_GRID_SIZE, 32'd0);
      foreach (edge_grid[i]) send_sample(edge_grid[i]);
      end_stream();
   endtask

   // sink holds off while the source keeps offering; then a source pause mid-grid
   task automatic test_backpressure();
      drain_results();
      csr_write(REG_RATE_COEFF, 32'h0000_4000);
      csr_write(REG_GRID_SIZE, 32'd6);
      send_gaps_on = 1'b0;
      hold_request = HOLD_CYCLES;
      send_samples(72, STYLE_SMALL);
      send_samples(20, STYLE_FULL);
      drain_results();
      send_samples(16, STYLE_SMALL);
      send_gaps_on = 1'b1;
   endtask

   // long stretch with no idling on either side
   task automatic test_steady_stream();
      drain_results();
      csr_write(REG_RATE_COEFF, 32'h0000_7FFF);
      csr_write(REG_GRID_SIZE, 32'd5);
      send_gaps_on   = 1'b0;
      sink_stalls_on = 1'b0;
      send_samples(75, STYLE_SMALL);
      send_gaps_on   = 1'b1;
      sink_stalls_on = 1'b1;
   endtask

   // random grids: one full-size grid, then mostly small grids, some broken off
   // with register changes in the middle of a grid
   task automatic test_random_grids();
      int unsigned sent;
      int unsigned count;
      int unsigned pick;
      drain_results();
      csr_write(REG_RATE_COEFF, $urandom_range(0, 16384));
      csr_write(REG_GRID_SIZE, 32'd63);
      send_samples(GRID_MAX_DEFAULT * GRID_MAX_DEFAULT, STYLE_SMALL);
      sent = GRID_MAX_DEFAULT * GRID_MAX_DEFAULT;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(99) < 35) begin
            drain_results();
            if ($urandom_range(1) == 1) begin
               case ($urandom_range(3))
                  0:       csr_write(REG_RATE_COEFF, 32'd0);
                  1:       csr_write(REG_RATE_COEFF, 32'h0000_FFFF);
                  2:       csr_write(REG_RATE_COEFF, $urandom_range(0, 16384));
                  default: csr_write(REG_RATE_COEFF, $urandom);
               endcase
            end
            if ($urandom_range(1) == 1) begin
               pick = $urandom_range(99);
               if (pick < 10)      csr_write(REG_GRID_SIZE, $urandom_range(0, 2));
               else if (pick < 20) csr_write(REG_GRID_SIZE, $urandom_range(10, 14));
               else                csr_write(REG_GRID_SIZE, $urandom_range(3, 9));
            end
         end
         count = samples_left_in_grid();
         if (count == 0) count = clamp_side(side_reg) * clamp_side(side_reg);
         if ($urandom_range(99) < 15) count = $urandom_range(1, count);
         send_samples(count, sample_style_type'($urandom_range(2)));
         sent += count;
      end
   endtask

   // result sink: random stalls, or a long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold_request - 1) @(negedge clock);
            hold_request = 0;
         end else begin
            rsp_chan.ready <= !(sink_stalls_on && $urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // compare each taken result with the oldest queued one
   always @(posedge clock) begin : result_check
      updated_cell_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (updated_cells.size() == 0) begin
            $display("%0t: unexpected item, expected none, got temp_out %h grid_done %b",
                     $time, rsp_chan.temp_out, rsp_chan.grid_done);
            failures++;
         end else begin
            want = updated_cells.pop_front();
            if (rsp_chan.temp_out !== want.temp) begin
               $display("%0t: temp_out mismatch, expected %h, got %h",
                        $time, want.temp, rsp_chan.temp_out);
               failures++;
            end
            if (rsp_chan.grid_done !== want.done) begin
               $display("%0t: grid_done mismatch, expected %b, got %b",
                        $time, want.done, rsp_chan.grid_done);
               failures++;
            end
         end
      end
   end

   // run limit
   initial begin : watchdog
      int cycle_count;
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("FAIL heat_stencil_2d_step");
      $finish;
   end

   // reset, tests in turn, final verdict
   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.temp_in = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      foreach (line_mem[b, i]) line_mem[b][i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_directed_grids();
      test_backpressure();
      test_steady_stream();
      test_random_grids();
      drain_results();

      if (failures == 0) begin
         $display("PASS heat_stencil_2d_step");
      end else begin
         $display("FAIL heat_stencil_2d_step");
      end
      $finish;
   end

endmodule

`default_nettype wire
